### design/ctgc_pkg.sv
// Shared definitions for the Cayley table group check block.
// Holds the fixed field widths, verdict codes and the queue control struct.
// No dependencies.
package ctgc_pkg;

    localparam int ENTRY_W = 8;
    localparam int ORDER_W = 7;
    localparam int CODE_W  = 3;

    localparam logic [CODE_W-1:0] FAIL_NONE     = 3'd0;
    localparam logic [CODE_W-1:0] FAIL_CLOSURE  = 3'd1;
    localparam logic [CODE_W-1:0] FAIL_ASSOC    = 3'd2;
    localparam logic [CODE_W-1:0] FAIL_IDENTITY = 3'd3;
    localparam logic [CODE_W-1:0] FAIL_INVERSE  = 3'd4;

    // Control bits that travel with each table write through the queue.
    typedef struct packed {
        logic last;  // final entry of the table
        logic bad;   // some entry of this table fell outside 1..n
    } wr_ctl_t;

endpackage

### design/ctgc_ram.sv
// Generic simple-dual-port RAM: one write port, two registered read ports.
// No dependencies.
module ctgc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr0,
    output logic [WIDTH-1:0]         rdata0,
    input  logic [$clog2(DEPTH)-1:0] raddr1,
    output logic [WIDTH-1:0]         rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule

### design/ctgc_fifo.sv
// Small show-ahead FIFO between the load front end and the check engine.
// No package dependencies.
module ctgc_fifo #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full) else $error("queue written while full");
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty) else $error("queue read while empty");
`endif

endmodule

### design/ctgc_front.sv
// Load front end: accepts table entries, range-checks them and queues writes.
// Depends on ctgc_pkg.
module ctgc_front #(
    parameter int MAX_ORDER = 64
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_clear,
    input  logic [$clog2(MAX_ORDER+1)-1:0]         n,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [ctgc_pkg::ENTRY_W-1:0]           s_entry,
    output logic                                  q_push,
    input  logic                                  q_full,
    output logic [$clog2(MAX_ORDER*MAX_ORDER)-1:0] q_addr,
    output logic [$clog2(MAX_ORDER)-1:0]           q_data,
    output ctgc_pkg::wr_ctl_t                      q_ctl
);

    import ctgc_pkg::*;

    localparam int EW = $clog2(MAX_ORDER);
    localparam int NW = $clog2(MAX_ORDER + 1);
    localparam int AW = $clog2(MAX_ORDER * MAX_ORDER);

    logic [EW-1:0] col_reg, col_next;
    logic [EW-1:0] row_reg, row_next;
    logic [AW-1:0] load_count_reg, load_count_next;
    logic          bad_reg, bad_next;
    logic [EW-1:0] n_m1;
    logic          accept;
    logic          range_bad;
    logic          last;

    assign n_m1      = EW'(n - NW'(1));
    assign s_ready   = !q_full;
    assign accept    = s_valid && s_ready;
    assign range_bad = (s_entry == '0) || (int'(s_entry) > int'(n));
    assign last      = (col_reg == n_m1) && (row_reg == n_m1);

    assign q_push   = accept;
    assign q_addr   = load_count_reg;
    assign q_data   = range_bad ? '0 : EW'(s_entry - ENTRY_W'(1));
    assign q_ctl.last = last;
    assign q_ctl.bad  = bad_reg || range_bad;

    always_comb begin
        col_next        = col_reg;
        row_next        = row_reg;
        load_count_next = load_count_reg;
        bad_next        = bad_reg;
        if (cfg_clear) begin
            col_next        = '0;
            row_next        = '0;
            load_count_next = '0;
            bad_next        = 1'b0;
        end else if (accept) begin
            if (last) begin
                // start the next table
                col_next        = '0;
                row_next        = '0;
                load_count_next = '0;
                bad_next        = 1'b0;
            end else begin
                load_count_next = load_count_reg + AW'(1);
                bad_next        = q_ctl.bad;
                if (col_reg == n_m1) begin
                    col_next = '0;
                    row_next = row_reg + EW'(1);
                end else begin
                    col_next = col_reg + EW'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg        <= '0;
            row_reg        <= '0;
            load_count_reg <= '0;
            bad_reg        <= 1'b0;
        end else begin
            col_reg        <= col_next;
            row_reg        <= row_next;
            load_count_reg <= load_count_next;
            bad_reg        <= bad_next;
        end
    end

endmodule

### design/ctgc_back.sv
// Check engine: drains queued writes into the table RAM, then walks the
// associativity, identity and inverse tests and registers the verdict.
// Depends on ctgc_pkg; drives the ports of a ctgc_ram instance.
module ctgc_back #(
    parameter int MAX_ORDER = 64
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic [$clog2(MAX_ORDER+1)-1:0]         n,
    input  logic                                  q_empty,
    output logic                                  q_pop,
    input  logic [$clog2(MAX_ORDER*MAX_ORDER)-1:0] q_addr,
    input  logic [$clog2(MAX_ORDER)-1:0]           q_data,
    input  ctgc_pkg::wr_ctl_t                      q_ctl,
    output logic                                  ram_we,
    output logic [$clog2(MAX_ORDER*MAX_ORDER)-1:0] ram_waddr,
    output logic [$clog2(MAX_ORDER)-1:0]           ram_wdata,
    output logic [$clog2(MAX_ORDER*MAX_ORDER)-1:0] ram_raddr0,
    input  logic [$clog2(MAX_ORDER)-1:0]           ram_rdata0,
    output logic [$clog2(MAX_ORDER*MAX_ORDER)-1:0] ram_raddr1,
    input  logic [$clog2(MAX_ORDER)-1:0]           ram_rdata1,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_is_group,
    output logic [ctgc_pkg::CODE_W-1:0]            m_fail_code
);

    import ctgc_pkg::*;

    localparam int EW = $clog2(MAX_ORDER);
    localparam int NW = $clog2(MAX_ORDER + 1);
    localparam int AW = $clog2(MAX_ORDER * MAX_ORDER);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_AS_IJ = 3'd1;
    localparam logic [2:0] ST_AS_IW = 3'd2;
    localparam logic [2:0] ST_AS_P0 = 3'd3;
    localparam logic [2:0] ST_AS_P1 = 3'd4;
    localparam logic [2:0] ST_ID    = 3'd5;
    localparam logic [2:0] ST_INV   = 3'd6;
    localparam logic [2:0] ST_OUT   = 3'd7;

    logic [2:0]        state_reg, state_next;
    logic [EW-1:0]     i_reg, i_next;
    logic [NW-1:0]     j_reg, j_next;
    logic [NW-1:0]     k_reg, k_next;
    logic [AW-1:0]     base_i_reg, base_i_next;
    logic [AW-1:0]     base_j_reg, base_j_next;
    logic [AW-1:0]     base_ij_reg, base_ij_next;
    logic [EW-1:0]     exp_reg, exp_next;
    logic [EW-1:0]     jd_reg, jd_next;
    logic              pend_reg, pend_next;
    logic [EW-1:0]     id_reg, id_next;
    logic [CODE_W-1:0] code_reg, code_next;
    logic              m_valid_reg;
    logic              m_is_group_reg;
    logic [CODE_W-1:0] m_fail_code_reg;
    logic              out_load;
    logic [AW-1:0]     n_aw;
    logic              i_last;
    logic              j_last;

    assign n_aw   = AW'(n);
    assign i_last = (i_reg == EW'(n - NW'(1)));
    assign j_last = (j_reg == (n - NW'(1)));

    assign ram_waddr = q_addr;
    assign ram_wdata = q_data;

    always_comb begin
        state_next   = state_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        k_next       = k_reg;
        base_i_next  = base_i_reg;
        base_j_next  = base_j_reg;
        base_ij_next = base_ij_reg;
        exp_next     = exp_reg;
        jd_next      = jd_reg;
        pend_next    = pend_reg;
        id_next      = id_reg;
        code_next    = code_reg;
        q_pop        = 1'b0;
        ram_we       = 1'b0;
        ram_raddr0   = '0;
        ram_raddr1   = '0;
        out_load     = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    q_pop  = 1'b1;
                    ram_we = 1'b1;
                    if (q_ctl.last) begin
                        i_next      = '0;
                        j_next      = '0;
                        base_i_next = '0;
                        base_j_next = '0;
                        if (q_ctl.bad) begin
                            code_next  = FAIL_CLOSURE;
                            state_next = ST_OUT;
                        end else begin
                            state_next = ST_AS_IJ;
                        end
                    end
                end
            end
            ST_AS_IJ: begin
                ram_raddr0 = base_i_reg + AW'(j_reg);
                state_next = ST_AS_IW;
            end
            ST_AS_IW: begin
                base_ij_next = AW'(ram_rdata0) * n_aw;
                k_next       = '0;
                state_next   = ST_AS_P0;
            end
            ST_AS_P0: begin
                // compare (ij)k against i(jk) of the previous k
                if ((k_reg != '0) && (ram_rdata0 != exp_reg)) begin
                    code_next  = FAIL_ASSOC;
                    state_next = ST_OUT;
                end else if (k_reg == n) begin
                    if (j_last) begin
                        j_next      = '0;
                        base_j_next = '0;
                        if (i_last) begin
                            i_next      = '0;
                            base_i_next = '0;
                            pend_next   = 1'b0;
                            state_next  = ST_ID;
                        end else begin
                            i_next      = i_reg + EW'(1);
                            base_i_next = base_i_reg + n_aw;
                            state_next  = ST_AS_IJ;
                        end
                    end else begin
                        j_next      = j_reg + NW'(1);
                        base_j_next = base_j_reg + n_aw;
                        state_next  = ST_AS_IJ;
                    end
                end else begin
                    ram_raddr0 = base_j_reg + AW'(k_reg);
                    ram_raddr1 = base_ij_reg + AW'(k_reg);
                    state_next = ST_AS_P1;
                end
            end
            ST_AS_P1: begin
                ram_raddr0 = base_i_reg + AW'(ram_rdata0);
                exp_next   = ram_rdata1;
                k_next     = k_reg + NW'(1);
                state_next = ST_AS_P0;
            end
            ST_ID: begin
                if (pend_reg && ((ram_rdata0 != jd_reg) || (ram_rdata1 != jd_reg))) begin
                    if (i_last) begin
                        code_next  = FAIL_IDENTITY;
                        state_next = ST_OUT;
                    end else begin
                        // drop this candidate, try the next row
                        i_next      = i_reg + EW'(1);
                        base_i_next = base_i_reg + n_aw;
                        j_next      = '0;
                        base_j_next = '0;
                        pend_next   = 1'b0;
                    end
                end else if (j_reg == n) begin
                    id_next     = i_reg;
                    i_next      = '0;
                    base_i_next = '0;
                    j_next      = '0;
                    base_j_next = '0;
                    pend_next   = 1'b0;
                    state_next  = ST_INV;
                end else begin
                    ram_raddr0  = base_i_reg + AW'(j_reg);
                    ram_raddr1  = base_j_reg + AW'(i_reg);
                    jd_next     = EW'(j_reg);
                    pend_next   = 1'b1;
                    j_next      = j_reg + NW'(1);
                    base_j_next = base_j_reg + n_aw;
                end
            end
            ST_INV: begin
                if (pend_reg && (ram_rdata0 == id_reg) && (ram_rdata1 == id_reg)) begin
                    if (i_last) begin
                        code_next  = FAIL_NONE;
                        state_next = ST_OUT;
                    end else begin
                        i_next      = i_reg + EW'(1);
                        base_i_next = base_i_reg + n_aw;
                        j_next      = '0;
                        base_j_next = '0;
                        pend_next   = 1'b0;
                    end
                end else if (j_reg == n) begin
                    code_next  = FAIL_INVERSE;
                    state_next = ST_OUT;
                end else begin
                    ram_raddr0  = base_i_reg + AW'(j_reg);
                    ram_raddr1  = base_j_reg + AW'(i_reg);
                    pend_next   = 1'b1;
                    j_next      = j_reg + NW'(1);
                    base_j_next = base_j_reg + n_aw;
                end
            end
            ST_OUT: begin
                // hold the verdict until the output register frees up
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        i_reg       <= i_next;
        j_reg       <= j_next;
        k_reg       <= k_next;
        base_i_reg  <= base_i_next;
        base_j_reg  <= base_j_next;
        base_ij_reg <= base_ij_next;
        exp_reg     <= exp_next;
        jd_reg      <= jd_next;
        id_reg      <= id_next;
        code_reg    <= code_next;
        if (out_load) begin
            m_is_group_reg  <= (code_reg == FAIL_NONE);
            m_fail_code_reg <= code_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_is_group  = m_is_group_reg;
    assign m_fail_code = m_fail_code_reg;

`ifndef SYNTHESIS
    a_verdict_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_is_group_reg == (m_fail_code_reg == FAIL_NONE)))
        else $error("verdict flag and code disagree");
    a_pop_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> (state_reg == ST_IDLE))
        else $error("queue drained while a check runs");
    a_identity_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_INV) |-> (NW'(id_reg) < n))
        else $error("identity index beyond order");
`endif

endmodule

### design/cayley_table_group_check.sv
// Cayley table group check, top level.
// Block usage:
//   cfg_we/cfg_wdata write the order n (0 reads as 1, values above MAX_ORDER
//   saturate); a write also restarts the table load. Write only while idle.
//   s_valid/s_ready/s_entry carry the n*n table entries, 1-based, row major.
//   m_valid/m_ready carry one verdict per table: m_is_group and m_fail_code
//   (0 ok, 1 not closed, 2 not associative, 3 no identity, 4 no inverse).
// Throughput: entries are taken one per cycle, while the queue has room, into
//   a 4-deep queue; the check engine writes them to the table RAM at one per
//   cycle while it is idle. After the last entry the engine runs the tests:
//   the associativity walk (two RAM reads and one dependent read per triple),
//   then the identity and inverse search. A closure failure skips the tests
//   and goes straight to the verdict.
// While the engine checks, the front keeps accepting the next table until
//   the queue fills. A verdict waits in the output register when m_ready is
//   low; the engine stalls only when a second verdict is ready behind it.
// Reset (aresetn low, synchronous) sets n to 1 and empties queue and output;
//   the table RAM is not cleared.
// Depends on ctgc_pkg, ctgc_front, ctgc_fifo, ctgc_ram and ctgc_back.
module cayley_table_group_check #(
    parameter int MAX_ORDER   = 64,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [ctgc_pkg::ORDER_W-1:0]    cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [ctgc_pkg::ENTRY_W-1:0]    s_entry,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_is_group,
    output logic [ctgc_pkg::CODE_W-1:0]     m_fail_code
);

    import ctgc_pkg::*;

    localparam int EW = $clog2(MAX_ORDER);
    localparam int NW = $clog2(MAX_ORDER + 1);
    localparam int AW = $clog2(MAX_ORDER * MAX_ORDER);
    localparam int QW = $bits(wr_ctl_t) + AW + EW;

    logic [NW-1:0] n_reg, n_next;

    logic          f_push;
    logic          q_full;
    logic [AW-1:0] f_addr;
    logic [EW-1:0] f_data;
    wr_ctl_t       f_ctl;
    logic [QW-1:0] q_din;
    logic [QW-1:0] q_dout;
    logic          q_empty;
    logic          q_pop;
    logic [AW-1:0] b_addr;
    logic [EW-1:0] b_data;
    wr_ctl_t       b_ctl;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr0;
    logic [EW-1:0] ram_rdata0;
    logic [AW-1:0] ram_raddr1;
    logic [EW-1:0] ram_rdata1;

    always_comb begin
        if (cfg_wdata == '0) begin
            n_next = NW'(1);
        end else if (int'(cfg_wdata) > MAX_ORDER) begin
            n_next = NW'(MAX_ORDER);
        end else begin
            n_next = NW'(cfg_wdata);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg <= NW'(1);
        end else if (cfg_we) begin
            n_reg <= n_next;
        end
    end

    ctgc_front #(
        .MAX_ORDER (MAX_ORDER)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_clear (cfg_we),
        .n         (n_reg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_entry   (s_entry),
        .q_push    (f_push),
        .q_full    (q_full),
        .q_addr    (f_addr),
        .q_data    (f_data),
        .q_ctl     (f_ctl)
    );

    assign q_din = {f_ctl, f_addr, f_data};

    ctgc_fifo #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (f_push),
        .din     (q_din),
        .full    (q_full),
        .pop     (q_pop),
        .dout    (q_dout),
        .empty   (q_empty)
    );

    assign {b_ctl, b_addr, b_data} = q_dout;

    ctgc_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_ORDER * MAX_ORDER)
    ) u_table (
        .aclk   (aclk),
        .we     (ram_we),
        .waddr  (ram_waddr),
        .wdata  (ram_wdata),
        .raddr0 (ram_raddr0),
        .rdata0 (ram_rdata0),
        .raddr1 (ram_raddr1),
        .rdata1 (ram_rdata1)
    );

    ctgc_back #(
        .MAX_ORDER (MAX_ORDER)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .n           (n_reg),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .q_addr      (b_addr),
        .q_data      (b_data),
        .q_ctl       (b_ctl),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_raddr0  (ram_raddr0),
        .ram_rdata0  (ram_rdata0),
        .ram_raddr1  (ram_raddr1),
        .ram_rdata1  (ram_rdata1),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_is_group  (m_is_group),
        .m_fail_code (m_fail_code)
    );

endmodule

### verif/cayley_table_group_check_tb.sv
// Testbench for cayley_table_group_check: streams multiplication tables of many
// orders and checks each group verdict against an in-bench predictor.
// Depends on ctgc_pkg and the cayley_table_group_check RTL.
module cayley_table_group_check_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ctgc_pkg::*;

    localparam int     MAX_ORDER     = 64;
    localparam int     RANDOM_ITEMS  = 680;
    localparam int     SETTLE_CYCLES = 64;
    localparam int     TAIL_CYCLES   = 200;
    localparam longint CYCLE_LIMIT   = 2_000_000;

    typedef struct packed {
        logic              is_group;
        logic [CODE_W-1:0] code;
    } verdict_t;

    typedef enum int {
        TBL_CYCLIC,
        TBL_CYCLIC_TWEAK,
        TBL_CYCLIC_STRAY,
        TBL_MAX_MONOID,
        TBL_LEFT_ZERO,
        TBL_SUBTRACT,
        TBL_RANDOM_IN,
        TBL_NOISE
    } table_kind_e;

    // Predicts one verdict per completed table and holds it until the block answers.
    class group_verdict_board;
        logic [5:0]  cells [MAX_ORDER*MAX_ORDER];
        int unsigned order_n;
        int unsigned fill;
        int unsigned identity;
        bit          stray_seen;
        verdict_t    verdict_q[$];
        int          errors;
        int          code_seen[5];

        function new();
            order_n    = 1;
            fill       = 0;
            identity   = 0;
            stray_seen = 0;
            errors     = 0;
            foreach (code_seen[i]) code_seen[i] = 0;
        endfunction

        function void set_order(logic [ORDER_W-1:0] v);
            order_n    = (v == 0) ? 1 : (v > MAX_ORDER) ? MAX_ORDER : v;
            fill       = 0;
            stray_seen = 0;
        endfunction

        function int unsigned at(int unsigned r, int unsigned c);
            return cells[(r*order_n + c) % (MAX_ORDER*MAX_ORDER)];
        endfunction

        function logic [CODE_W-1:0] judge();
            int unsigned ij;
            bit          found;
            bit          ok;
            found = 0;
            if (stray_seen) return FAIL_CLOSURE;
            for (int unsigned i = 0; i < order_n; i++)
                for (int unsigned j = 0; j < order_n; j++) begin
                    ij = at(i, j);
                    for (int unsigned k = 0; k < order_n; k++)
                        if (at(ij, k) != at(i, at(j, k))) return FAIL_ASSOC;
                end
            // keep the lowest index that works on both sides
            for (int unsigned i = 0; i < order_n && !found; i++) begin
                ok = 1;
                for (int unsigned j = 0; j < order_n; j++)
                    if (at(i, j) != j || at(j, i) != j) ok = 0;
                if (ok) begin
                    identity = i;
                    found    = 1;
                end
            end
            if (!found) return FAIL_IDENTITY;
            for (int unsigned i = 0; i < order_n; i++) begin
                ok = 0;
                for (int unsigned j = 0; j < order_n; j++)
                    if (at(i, j) == identity && at(j, i) == identity) ok = 1;
                if (!ok) return FAIL_INVERSE;
            end
            return FAIL_NONE;
        endfunction

        function void note_entry(logic [ENTRY_W-1:0] e);
            int unsigned total;
            verdict_t    v;
            total = order_n * order_n;
            if (fill >= total) fill = 0;
            // store an out-of-range entry as element 0 and keep loading
            if (e < 1 || e > order_n) begin
                stray_seen  = 1;
                cells[fill] = '0;
            end else begin
                cells[fill] = 6'(e - 1);
            end
            fill++;
            if (fill == total) begin
                v.code     = judge();
                v.is_group = (v.code == FAIL_NONE);
                verdict_q  = {verdict_q, v};
                fill       = 0;
                stray_seen = 0;
            end
        endfunction

        function void check_result(logic is_group, logic [CODE_W-1:0] code);
            verdict_t want;
            if (verdict_q.size() == 0) begin
                $display("%0t: verdict with none pending: is_group=%0d fail_code=%0d",
                         $time, is_group, code);
                errors++;
                return;
            end
            want = verdict_q.pop_front();
            code_seen[want.code]++;
            if (is_group !== want.is_group) begin
                $display("%0t: is_group mismatch: expected %0d, actual %0d",
                         $time, want.is_group, is_group);
                errors++;
            end
            if (code !== want.code) begin
                $display("%0t: fail_code mismatch: expected %0d, actual %0d",
                         $time, want.code, code);
                errors++;
            end
        endfunction
    endclass

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [ORDER_W-1:0] cfg_wdata = '0;
    logic               s_valid   = 1'b0;
    logic               s_ready;
    logic [ENTRY_W-1:0] s_entry   = '0;
    logic               m_valid;
    logic               m_ready   = 1'b0;
    logic               m_is_group;
    logic [CODE_W-1:0]  m_fail_code;

    group_verdict_board board;
    int                 send_idle_pct  = 0;
    int                 recv_stall_pct = 0;
    int                 entries_sent   = 0;
    longint             cycle_count    = 0;

    cayley_table_group_check uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_entry    (s_entry),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_is_group (m_is_group),
        .m_fail_code(m_fail_code)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        forever begin
            @(negedge aclk);
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid === 1'b1 && m_ready === 1'b1)
            board.check_result(m_is_group, m_fail_code);
    end

    // Call at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_entry(input logic [ENTRY_W-1:0] e);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_entry <= e;
        do @(posedge aclk); while (s_ready !== 1'b1);
        board.note_entry(e);
        entries_sent++;
        @(negedge aclk);
    endtask

    task automatic send_four(input logic [ENTRY_W-1:0] a, b, c, d);
        send_entry(a);
        send_entry(b);
        send_entry(c);
        send_entry(d);
    endtask

    // Hold requests until every verdict is back, then let the input queue drain.
    task automatic write_order(input logic [ORDER_W-1:0] v);
        s_valid <= 1'b0;
        while (board.verdict_q.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we <= 1'b0;
        board.set_order(v);
    endtask

    function automatic table_kind_e pick_kind();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 30) return TBL_CYCLIC;
        if (roll < 45) return TBL_CYCLIC_TWEAK;
        if (roll < 55) return TBL_CYCLIC_STRAY;
        if (roll < 65) return TBL_MAX_MONOID;
        if (roll < 75) return TBL_LEFT_ZERO;
        if (roll < 85) return TBL_SUBTRACT;
        if (roll < 90) return TBL_RANDOM_IN;
        return TBL_NOISE;
    endfunction

    task automatic send_table(input table_kind_e kind, input int n);
        int                 perm [MAX_ORDER];
        int                 slot [MAX_ORDER];
        logic [ENTRY_W-1:0] cells_q[$];
        int                 r;
        int                 c;
        int                 tmp;
        int                 spot;
        for (int i = 0; i < n; i++) perm[i] = i;
        for (int i = n - 1; i > 0; i--) begin
            r       = $urandom_range(0, i);
            tmp     = perm[i];
            perm[i] = perm[r];
            perm[r] = tmp;
        end
        for (int i = 0; i < n; i++) slot[perm[i]] = i;
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++) begin
                case (kind)
                    TBL_MAX_MONOID: c = ((i > j) ? i : j) + 1;
                    TBL_LEFT_ZERO:  c = i + 1;
                    TBL_SUBTRACT:   c = (i - j + n) % n + 1;
                    TBL_RANDOM_IN:  c = $urandom_range(1, n);
                    TBL_NOISE:      c = $urandom_range(0, 255);
                    // cyclic group under a random relabeling
                    default:        c = perm[(slot[i] + slot[j]) % n] + 1;
                endcase
                cells_q = {cells_q, ENTRY_W'(c)};
            end
        spot = $urandom_range(0, n*n - 1);
        if (kind == TBL_CYCLIC_TWEAK)
            cells_q[spot] = ENTRY_W'($urandom_range(1, n));
        if (kind == TBL_CYCLIC_STRAY)
            cells_q[spot] = ($urandom_range(0, 1) == 0) ? '0
                                                        : ENTRY_W'($urandom_range(n + 1, 255));
        foreach (cells_q[k]) send_entry(cells_q[k]);
    endtask

    task automatic run_segment(input int budget);
        int n;
        int tables;
        n = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 6) : $urandom_range(7, 12);
        // shrink order and table count so the phase ends near its share of entries
        while (n > 1 && n*n > budget) n--;
        tables = $urandom_range(1, 4);
        while (tables > 1 && tables*n*n > budget) tables--;
        write_order(ORDER_W'(n));
        repeat (tables) send_table(pick_kind(), n);
        // leave a partial table behind so the next write restarts the load
        if (n > 1 && $urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, n*n - 1)) send_entry(ENTRY_W'($urandom_range(0, n + 1)));
    endtask

    initial begin
        int phase_goal;
        board = new();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // order zero acts as order one
        write_order('0);
        send_entry(8'd1);
        send_entry(8'd0);
        send_entry(8'd255);

        write_order(7'd2);
        send_four(8'd1, 8'd2, 8'd2, 8'd1);
        send_four(8'd1, 8'd1, 8'd1, 8'd1);
        send_four(8'd1, 8'd2, 8'd2, 8'd2);
        send_four(8'd2, 8'd2, 8'd2, 8'd1);

        // drop a half-loaded table by rewriting the order
        write_order(7'd3);
        send_entry(8'd2);
        send_entry(8'd3);
        write_order(7'd2);
        send_four(8'd2, 8'd1, 8'd1, 8'd2);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 72;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 72;
                end
                default: begin
                    send_idle_pct  = 28;
                    recv_stall_pct = 28;
                end
            endcase
            if (phase == 0) begin
                // all-ones order saturates to the largest table; abandon it part way
                write_order('1);
                repeat (20) send_entry(ENTRY_W'($urandom_range(0, MAX_ORDER + 8)));
            end
            if (phase == 2) begin
                write_order(ORDER_W'(MAX_ORDER));
                repeat (30) send_entry(ENTRY_W'($urandom_range(1, MAX_ORDER)));
            end
            phase_goal = entries_sent + RANDOM_ITEMS / 4;
            while (entries_sent < phase_goal) run_segment(phase_goal - entries_sent);
        end

        s_valid <= 1'b0;
        while (board.verdict_q.size() != 0) @(negedge aclk);
        repeat (TAIL_CYCLES) @(negedge aclk);

        $display("Streamed %0d entries: whole tables of order 1 to 12 and partial loads",
                 entries_sent);
        $display("at order 64, under four idle/stall mixes; verdicts: %0d group, %0d %s",
                 board.code_seen[FAIL_NONE], board.code_seen[FAIL_CLOSURE], "not closed,");
        $display("%0d not associative, %0d no identity, %0d no inverse",
                 board.code_seen[FAIL_ASSOC], board.code_seen[FAIL_IDENTITY],
                 board.code_seen[FAIL_INVERSE]);
        if (board.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
